>>> rtl/core/assert_macros.svh
// assertion macros used by the speed controller rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: ante |-> cons");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: ante |=> cons");

`endif

>>> rtl/core/espc_pkg.sv
// shared types and constants for the encoder speed pi controller
// no dependencies
package espc_pkg;

  // moving average window, power of two so the mean is a shift
  localparam int WINDOW_LOG2 = 3;
  localparam int WINDOW_LEN  = 1 << WINDOW_LOG2;
  localparam int SUM_W       = 32 + WINDOW_LOG2;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_SPEED,
    REG_PROP_GAIN,
    REG_INT_GAIN,
    REG_SPEED_SCALE
  } cfg_reg_t;

  // speed limit of 1e4 deg/s in q20.12, plus one
  localparam logic [25:0] SPEED_LIMIT_P1 = 26'd40960001;
  localparam int QUOT_W    = 26;
  localparam int DIV_STEPS = QUOT_W;

  // serial multiplier: 64 x 64, one 16 bit digit per cycle
  localparam int MUL_OP_W    = 64;
  localparam int MUL_DIGIT_W = 16;
  localparam int MUL_STEPS   = MUL_OP_W / MUL_DIGIT_W;

  localparam logic [9:0] DRIVE_LIMIT = 10'd850;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_PREP,
    OP_MUL,
    OP_CHECK,
    OP_DIV,
    OP_WIN,
    OP_ERR,
    OP_INTEG,
    OP_LD_I,
    OP_ITERM,
    OP_DRIVE
  } dp_op_t;

  typedef struct packed {
    logic signed [31:0] encoder_count;
    logic        [31:0] interval_ns;
  } in_item_t;

  typedef struct packed {
    logic signed [10:0] drive;
    logic               speed_rejected;
  } out_item_t;

endpackage

>>> rtl/core/espc_dp.sv
// datapath: config registers, window, integrator, serial multiplier and divider
// depends on espc_pkg
module espc_dp import espc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_op_t                op,
  input  in_item_t              in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output out_item_t             out_data
);

  logic signed [31:0] target_speed;
  logic signed [31:0] prop_gain;
  logic signed [47:0] int_gain;
  logic        [47:0] speed_scale;

  logic signed [31:0]      prev_count;
  logic signed [31:0]      window [WINDOW_LEN];
  logic signed [SUM_W-1:0] win_sum;
  logic signed [63:0]      integ;

  logic signed [31:0] count_in;
  logic        [31:0] ns;
  logic               dneg;
  logic        [57:0] limit;
  logic [MUL_OP_W-1:0] mul_a;
  logic [MUL_OP_W-1:0] mul_b;
  logic [127:0]       prod;
  logic [31:0]        rem;
  logic [QUOT_W-1:0]  dq;
  logic               rejected;
  logic signed [32:0] err;
  logic               ineg;
  logic               outneg;

  // speed from encoder delta
  logic signed [32:0] delta;
  logic        [32:0] dmag;
  logic        [57:0] limit_next;
  assign delta      = {count_in[31], count_in} - {prev_count[31], prev_count};
  assign dmag       = delta[32] ? 33'(-delta) : 33'(delta);
  assign limit_next = {26'b0, ns} * {32'b0, SPEED_LIMIT_P1};

  // one multiplier digit, msb first
  logic [MUL_OP_W+MUL_DIGIT_W-1:0] partial;
  logic [127:0]                    prod_next;
  assign partial   = mul_a * mul_b[MUL_OP_W-1 -: MUL_DIGIT_W];
  assign prod_next = (prod << MUL_DIGIT_W) + {{(128-MUL_OP_W-MUL_DIGIT_W){1'b0}}, partial};

  // restoring divider step
  logic [32:0] div_t;
  logic        div_ge;
  logic [32:0] div_diff;
  assign div_t    = {rem, dq[QUOT_W-1]};
  assign div_ge   = div_t >= {1'b0, ns};
  assign div_diff = div_t - {1'b0, ns};

  // window update
  logic signed [31:0]      qs;
  logic signed [31:0]      speed_new;
  logic signed [SUM_W-1:0] sum_next;
  assign qs        = {{(32-QUOT_W){1'b0}}, dq};
  assign speed_new = rejected ? window[0] : (dneg ? 32'(-qs) : qs);
  assign sum_next  = win_sum + SUM_W'(speed_new) - SUM_W'(window[WINDOW_LEN-1]);

  // mean truncated toward zero, then error
  logic signed [SUM_W-1:0] mean_full;
  logic signed [31:0]      mean;
  logic signed [32:0]      err_next;
  logic        [32:0]      err_mag;
  assign mean_full = (win_sum + (win_sum[SUM_W-1] ? SUM_W'(WINDOW_LEN - 1) : SUM_W'(0)))
                     >>> WINDOW_LOG2;
  assign mean      = mean_full[31:0];
  assign err_next  = {target_speed[31], target_speed} - {mean[31], mean};
  assign err_mag   = err_next[32] ? 33'(-err_next) : 33'(err_next);

  // saturating integrator add
  logic        [63:0] int_m;
  logic signed [65:0] int_s;
  logic signed [63:0] integ_next;
  assign int_m = (prod[127:64] != '0) ? '1 : prod[63:0];
  assign int_s = {{2{integ[63]}}, integ} + (err[32] ? 66'(-{2'b0, int_m}) : {2'b0, int_m});
  always_comb begin
    if (!int_s[65] && int_s[64:63] != 2'b00) begin
      integ_next = {1'b0, {63{1'b1}}};
    end else if (int_s[65] && int_s[64:63] != 2'b11) begin
      integ_next = {1'b1, 63'b0};
    end else begin
      integ_next = int_s[63:0];
    end
  end

  // operand magnitudes for the integral product
  logic [47:0] ig_mag;
  logic [63:0] ei_mag;
  assign ig_mag = int_gain[47] ? 48'(-int_gain) : 48'(int_gain);
  assign ei_mag = integ[63] ? 64'(-integ) : 64'(integ);

  // integral term and controller sum
  logic [87:0]        p40;
  logic [63:0]        imag;
  logic signed [63:0] iterm;
  logic signed [64:0] sum65;
  logic        [63:0] smag;
  logic        [31:0] kp_mag;
  assign p40    = prod[127:40];
  assign imag   = (p40 > (88'd1 << 62)) ? (64'd1 << 62) : p40[63:0];
  assign iterm  = ineg ? 64'(-imag) : 64'(imag);
  assign sum65  = {{32{err[32]}}, err} + {iterm[63], iterm};
  assign smag   = sum65[64] ? 64'(-sum65) : sum65[63:0];
  assign kp_mag = prop_gain[31] ? 32'(-prop_gain) : 32'(prop_gain);

  // drive scaling and saturation
  logic [99:0]        p28;
  logic [9:0]         dmagn;
  logic signed [10:0] drive_next;
  assign p28        = prod[127:28];
  assign dmagn      = (p28 > {90'b0, DRIVE_LIMIT}) ? DRIVE_LIMIT : p28[9:0];
  assign drive_next = outneg ? 11'(-{1'b0, dmagn}) : {1'b0, dmagn};

  // state cleared at reset: configuration, previous count, window, integrator
  always_ff @(posedge clk) begin
    if (rst) begin
      target_speed <= '0;
      prop_gain    <= '0;
      int_gain     <= '0;
      speed_scale  <= '0;
      prev_count   <= '0;
      win_sum      <= '0;
      integ        <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        window[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_TARGET_SPEED: target_speed <= cfg_data[31:0];
          REG_PROP_GAIN:    prop_gain    <= cfg_data[31:0];
          REG_INT_GAIN:     int_gain     <= cfg_data;
          REG_SPEED_SCALE:  speed_scale  <= cfg_data;
          default: ;
        endcase
      end
      if (op == OP_PREP) begin
        prev_count <= count_in;
      end
      if (op == OP_WIN) begin
        win_sum   <= sum_next;
        window[0] <= speed_new;
        for (int i = 1; i < WINDOW_LEN; i++) begin
          window[i] <= window[i-1];
        end
      end
      if (op == OP_INTEG) begin
        integ <= integ_next;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        count_in <= in_data.encoder_count;
        ns       <= in_data.interval_ns;
      end
      OP_PREP: begin
        dneg  <= delta[32];
        limit <= limit_next;
        mul_a <= 64'(dmag);
        mul_b <= 64'(speed_scale);
        prod  <= '0;
      end
      OP_MUL: begin
        prod  <= prod_next;
        mul_b <= mul_b << MUL_DIGIT_W;
      end
      OP_CHECK: begin
        rejected <= (ns == '0) || (prod[127:58] != '0) || (prod[57:0] >= limit);
        rem      <= prod[57:26];
        dq       <= prod[25:0];
      end
      OP_DIV: begin
        rem <= div_ge ? div_diff[31:0] : div_t[31:0];
        dq  <= {dq[QUOT_W-2:0], div_ge};
      end
      OP_ERR: begin
        err   <= err_next;
        mul_a <= 64'(err_mag);
        mul_b <= 64'(ns);
        prod  <= '0;
      end
      OP_LD_I: begin
        ineg  <= int_gain[47] ^ integ[63];
        mul_a <= 64'(ig_mag);
        mul_b <= ei_mag;
        prod  <= '0;
      end
      OP_ITERM: begin
        outneg <= prop_gain[31] ^ sum65[64];
        mul_a  <= 64'(kp_mag);
        mul_b  <= smag;
        prod   <= '0;
      end
      OP_DRIVE: begin
        out_data.drive          <= drive_next;
        out_data.speed_rejected <= rejected;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/espc_ctrl.sv
// controller: sequences one item through the datapath, owns the handshakes
// depends on espc_pkg and assert_macros.svh
`include "assert_macros.svh"
module espc_ctrl import espc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  output logic   out_valid,
  input  logic   out_ready,
  output dp_op_t op
);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_MUL_SPD, S_CHECK, S_DIV, S_WIN, S_ERR, S_MUL_ERR,
    S_INTEG, S_LD_I, S_MUL_I, S_ITERM, S_MUL_P, S_DRIVE
  } state_t;

  localparam int CNT_W = $clog2(DIV_STEPS);

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             out_free;
  logic             mul_last;
  logic             div_last;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign mul_last = (cnt == CNT_W'(MUL_STEPS - 1));
  assign div_last = (cnt == CNT_W'(DIV_STEPS - 1));

  // datapath command per state
  always_comb begin
    case (state)
      S_IDLE:    op = in_valid ? OP_LOAD : OP_NOP;
      S_PREP:    op = OP_PREP;
      S_MUL_SPD: op = OP_MUL;
      S_CHECK:   op = OP_CHECK;
      S_DIV:     op = OP_DIV;
      S_WIN:     op = OP_WIN;
      S_ERR:     op = OP_ERR;
      S_MUL_ERR: op = OP_MUL;
      S_INTEG:   op = OP_INTEG;
      S_LD_I:    op = OP_LD_I;
      S_MUL_I:   op = OP_MUL;
      S_ITERM:   op = OP_ITERM;
      S_MUL_P:   op = OP_MUL;
      S_DRIVE:   op = out_free ? OP_DRIVE : OP_NOP;
      default:   op = OP_NOP;
    endcase
  end

  // state, step counter and output beat flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // result beat flag: set on drive, cleared when taken
      if (state == S_DRIVE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE:  if (in_valid) state <= S_PREP;
        S_PREP:  state <= S_MUL_SPD;
        S_MUL_SPD: begin
          cnt <= mul_last ? '0 : cnt + 1'b1;
          if (mul_last) state <= S_CHECK;
        end
        S_CHECK: state <= S_DIV;
        S_DIV: begin
          cnt <= div_last ? '0 : cnt + 1'b1;
          if (div_last) state <= S_WIN;
        end
        S_WIN:   state <= S_ERR;
        S_ERR:   state <= S_MUL_ERR;
        S_MUL_ERR: begin
          cnt <= mul_last ? '0 : cnt + 1'b1;
          if (mul_last) state <= S_INTEG;
        end
        S_INTEG: state <= S_LD_I;
        S_LD_I:  state <= S_MUL_I;
        S_MUL_I: begin
          cnt <= mul_last ? '0 : cnt + 1'b1;
          if (mul_last) state <= S_ITERM;
        end
        S_ITERM: state <= S_MUL_P;
        S_MUL_P: begin
          cnt <= mul_last ? '0 : cnt + 1'b1;
          if (mul_last) state <= S_DRIVE;
        end
        S_DRIVE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `ASSERT_IMPLY(a_drive_needs_room, clk, rst, op == OP_DRIVE, !out_valid || out_ready)
  `ASSERT_NEXT(a_result_follows_drive, clk, rst, op == OP_DRIVE, out_valid)
  `ASSERT_IMPLY(a_div_count_range, clk, rst, state == S_DIV, cnt < CNT_W'(DIV_STEPS))

endmodule

>>> rtl/core/encoder_speed_pi_controller.sv
// channel  | beat     | handshake
// in       | in_data  | in_valid / in_ready
// out      | out_data | out_valid / out_ready
// cfg      | cfg_data | cfg_we, cfg_index (write only)
// an item is finished before the next is accepted; on its way it takes four passes of
// the serial multiplier (16 bit digit) and one of the restoring divider
// the result beat sits in an output register, so the next item is taken while it waits
// synchronous active-high reset clears config, window, integrator and handshake state
// top level of the encoder speed pi controller, depends on espc_pkg, espc_ctrl, espc_dp
module encoder_speed_pi_controller import espc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_op_t op;

  espc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .op        (op)
  );

  espc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

>>> bench/testbench.sv
// testbench for the encoder speed pi controller: directed and random items
// checked against an in-bench bit-accurate model of the speed and drive math
// depends on espc_pkg and encoder_speed_pi_controller
module testbench;
  import espc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [63:0] SPEED_MAX = 64'd40960000;
  localparam logic [63:0] S64_MAX = 64'h7fff_ffff_ffff_ffff;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // model state and registers
  logic signed [63:0] set_speed, kp, ki;
  logic [63:0] scale;
  logic signed [63:0] last_count, win_sum, integ;
  logic signed [31:0] speeds [WINDOW_LEN];
  int unsigned old_pos;

  out_item_t drive_queue [$];
  int mismatches = 0;
  int idle_pct = 10;
  int quiet_cycles = 0;
  logic sink_started = 1'b0;

  encoder_speed_pi_controller dut (.*);

  always #4 clk = ~clk;

  function automatic logic [63:0] mag(input logic signed [63:0] x);
    return x < 0 ? -x : x;
  endfunction

  // model one item and queue the expected drive beat
  task automatic predict_drive(input in_item_t it);
    logic signed [63:0] cnt, delta, speed, mean, err, iterm, s;
    logic [127:0] p;
    logic [63:0] ns, m, imag, dmag;
    logic rej;
    out_item_t r;
    cnt = 64'(it.encoder_count);
    ns = 64'(it.interval_ns);
    delta = cnt - last_count;
    last_count = cnt;
    rej = 1'b1;
    speed = 0;
    if (ns != 0) begin
      p = 128'(mag(delta)) * 128'(scale);
      if (p < 128'(SPEED_MAX + 1) * 128'(ns)) begin
        speed = 64'(p / 128'(ns));
        if (delta < 0) speed = -speed;
        rej = 1'b0;
      end
    end
    if (rej) speed = 64'(speeds[(old_pos + WINDOW_LEN - 1) % WINDOW_LEN]);
    win_sum = win_sum + speed - speeds[old_pos];
    speeds[old_pos] = speed[31:0];
    old_pos = (old_pos + 1) % WINDOW_LEN;
    mean = win_sum / WINDOW_LEN;
    err = set_speed - mean;
    p = 128'(mag(err)) * 128'(ns);
    m = p[127:64] != 0 ? 64'hffff_ffff_ffff_ffff : p[63:0];
    if (err >= 0) begin
      if (m > S64_MAX - 64'(integ)) integ = S64_MAX;
      else integ = integ + m;
    end else begin
      if (m > 64'(integ) - 64'h8000_0000_0000_0000) integ = 64'sh8000_0000_0000_0000;
      else integ = integ - m;
    end
    p = 128'(mag(ki)) * 128'(mag(integ));
    imag = p[103:40];
    if (p[127:104] != 0 || imag > (64'd1 << 62)) imag = 64'd1 << 62;
    iterm = ((ki < 0) != (integ < 0)) ? -imag : imag;
    s = err + iterm;
    p = 128'(mag(kp)) * 128'(mag(s));
    dmag = p[91:28];
    if (p[127:92] != 0 || dmag > 850) dmag = 850;
    r.drive = ((kp < 0) != (s < 0)) ? -11'(dmag) : 11'(dmag);
    r.speed_rejected = rej;
    drive_queue.push_back(r);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [47:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TARGET_SPEED: set_speed = $signed(val[31:0]);
      REG_PROP_GAIN: kp = $signed(val[31:0]);
      REG_INT_GAIN: ki = $signed(val);
      REG_SPEED_SCALE: scale = 64'(val);
      default: ;
    endcase
  endtask

  // send one beat, idling beforehand at random
  task automatic send_item(input logic signed [31:0] cnt, input logic [31:0] ns);
    in_item_t it;
    it.encoder_count = cnt;
    it.interval_ns = ns;
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict_drive(it);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (drive_queue.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_config();
    write_reg(REG_TARGET_SPEED, {16'd0, 32'($signed($urandom_range(0, 80000000)) - 40000000)});
    write_reg(REG_PROP_GAIN, {16'd0, 32'($signed($urandom_range(0, 800000)) - 400000)});
    write_reg(REG_INT_GAIN, {$urandom_range(0, 1) ? 16'hffff : 16'h0, 32'($urandom)});
    write_reg(REG_SPEED_SCALE, {16'd0, 32'($urandom_range(1, 20000000))});
  endtask

  // extremes of the fields and registers, zero time, overflow, wraparound
  task automatic test_directed();
    write_reg(REG_SPEED_SCALE, 48'd4096000);
    write_reg(REG_PROP_GAIN, 48'h0000_0001_0000);
    write_reg(REG_TARGET_SPEED, 48'h0000_0001_0000);
    send_item(32'sd10, 32'd1000000);
    send_item(32'sd20, 32'd0);
    send_item(32'sh7fff_ffff, 32'd1);
    send_item(32'sh8000_0000, 32'hffff_ffff);
    send_item(-32'sd5, 32'd1000000);
    send_item(32'sd0, 32'd1);
    drain();
    write_reg(REG_SPEED_SCALE, 48'hffff_ffff_ffff);
    write_reg(REG_PROP_GAIN, 48'h0000_7fff_ffff);
    write_reg(REG_INT_GAIN, 48'h7fff_ffff_ffff);
    write_reg(REG_TARGET_SPEED, 48'h0000_7fff_ffff);
    send_item(32'sd1, 32'hffff_ffff);
    send_item(32'sd1, 32'hffff_ffff);
    send_item(32'sd2, 32'hffff_ffff);
    drain();
    write_reg(REG_PROP_GAIN, 48'h0000_8000_0000);
    write_reg(REG_INT_GAIN, 48'h8000_0000_0000);
    write_reg(REG_TARGET_SPEED, 48'h0000_8000_0000);
    write_reg(REG_SPEED_SCALE, 48'd0);
    repeat (4) send_item(32'sd3, 32'hffff_ffff);
    drain();
  endtask

  // random phases: mostly plausible motion, some wild counts and zero times
  task automatic test_random();
    logic signed [31:0] cnt;
    cnt = last_count[31:0];
    for (int ph = 0; ph < 6; ph++) begin
      random_config();
      idle_pct = (ph == 2) ? 0 : 10;
      for (int i = 0; i < 250; i++) begin
        case ($urandom_range(9))
          0: send_item($urandom, $urandom);
          1: send_item(cnt, 32'd0);
          default: begin
            cnt = cnt + $signed($urandom_range(0, 4000)) - 2000;
            send_item(cnt, $urandom_range(100000, 20000000));
          end
        endcase
        cnt = last_count[31:0];
      end
      drain();
    end
  endtask

  // result checker and sink stalls
  always @(posedge clk) begin
    if (sink_started) out_ready <= ($urandom_range(99) >= idle_pct);
    if (!rst && out_valid && out_ready) begin
      if (drive_queue.size() == 0) begin
        $display("%0t: unexpected beat drive=%0d rej=%0b", $time, out_data.drive,
                 out_data.speed_rejected);
        mismatches++;
      end else begin
        out_item_t want;
        want = drive_queue.pop_front();
        if (out_data.drive !== want.drive) begin
          $display("%0t: drive expected %0d got %0d", $time, want.drive, out_data.drive);
          mismatches++;
        end
        if (out_data.speed_rejected !== want.speed_rejected) begin
          $display("%0t: rejected expected %0b got %0b", $time, want.speed_rejected,
                   out_data.speed_rejected);
          mismatches++;
        end
      end
    end
  end

  // watchdog on accepted beats and config writes
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    set_speed = 0; kp = 0; ki = 0; scale = 0;
    last_count = 0; win_sum = 0; integ = 0; old_pos = 0;
    for (int i = 0; i < WINDOW_LEN; i++) speeds[i] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    sink_started <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/espc_pkg.sv
rtl/core/espc_dp.sv
rtl/core/espc_ctrl.sv
rtl/core/encoder_speed_pi_controller.sv
bench/testbench.sv
